@@ rtl/bcmm_pkg.sv @@
package bcmm_pkg;

  // Result target codes
  localparam logic [2:0] TGT_NONE = 3'd0;
  localparam logic [2:0] TGT_BIOS = 3'd1;
  localparam logic [2:0] TGT_CART = 3'd2;
  localparam logic [2:0] TGT_SRAM = 3'd3;
  localparam logic [2:0] TGT_RAM  = 3'd4;

  // Source of the result byte
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_OPEN = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;
  localparam logic [1:0] SRC_SRAM = 2'd3;

  // Mapper kinds, latched by the first register write
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_HIGH    = 2'd1;
  localparam logic [1:0] KIND_SLOTREG = 2'd2;
  localparam logic [1:0] KIND_A000    = 2'd3;

  // 3D shutter field codes
  localparam logic [1:0] FIELD_NONE  = 2'd0;
  localparam logic [1:0] FIELD_LEFT  = 2'd1;
  localparam logic [1:0] FIELD_RIGHT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIOS_PRESENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIOS_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CART_PRESENT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_MASK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_CONTROL = 3'd4;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned ROM_AW     = 20;

  // Decode constants
  localparam logic [15:0] ADDR_FIELD_LO = 16'hfff8;
  localparam logic [15:0] ADDR_FIELD_HI = 16'hfffb;
  localparam logic [15:0] ADDR_CTRL     = 16'hfffc;
  localparam logic [15:0] ADDR_BANK0_HI = 16'hfffd;
  localparam logic [15:0] ADDR_BANK1_HI = 16'hfffe;
  localparam logic [15:0] ADDR_BANK2_HI = 16'hffff;
  localparam logic [15:0] ADDR_BANK0_LO = 16'h0000;
  localparam logic [15:0] ADDR_BANK1_LO = 16'h4000;
  localparam logic [15:0] ADDR_BANK2_LO = 16'h8000;
  localparam logic [15:0] ADDR_BANK2_A  = 16'ha000;
  localparam logic [15:0] ADDR_SRAM_LO  = 16'h8000;
  localparam logic [15:0] ADDR_SRAM_HI  = 16'hbfff;
  localparam logic [15:0] ADDR_RAM_LO   = 16'hc000;

  localparam logic [7:0] OPEN_BUS       = 8'hff;
  localparam int unsigned MC_BIOS_OFF_BIT = 3;
  localparam int unsigned MC_CART_OFF_BIT = 6;
  localparam int unsigned CTRL_SRAM_BIT   = 3;

  // Routing of one item toward the result
  typedef struct packed {
    logic [2:0]        target;
    logic [ROM_AW-1:0] rom_address;
    logic [1:0]        src;
  } route_t;

  // Memory access request of one item
  typedef struct packed {
    logic ram_en;
    logic ram_we;
    logic sram_en;
    logic sram_we;
  } mem_req_t;

endpackage

@@ rtl/banked_cartridge_memory_mapper.sv @@
// An accepted item is registered in the memory stage, then in the output stage; the
// output register loads only while it is empty or out_stall is low.
// Throughput: one item per cycle while out_stall is low and no clearing pass runs;
// the work RAM and cartridge SRAM each take one access per cycle and their
// registered read data sets the two-stage pipeline. Reset (rst_n low, synchronous)
// clears all mapper state, then both memories are cleared one entry per cycle, with
// in_stall high throughout; configuration writes are taken during that pass.
module banked_cartridge_memory_mapper #(
  parameter int RAM_DEPTH  = 8192,
  parameter int SRAM_DEPTH = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcmm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [15:0]                      in_address,
  input  logic [7:0]                       in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_target,
  output logic [bcmm_pkg::ROM_AW-1:0]      out_rom_address,
  output logic [7:0]                       out_read_data,
  output logic [1:0]                       out_glasses_field,
  output logic                             out_sram_dirty
);

  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int SRAM_AW   = $clog2(SRAM_DEPTH);
  localparam int MAX_DEPTH = (RAM_DEPTH > SRAM_DEPTH) ? RAM_DEPTH : SRAM_DEPTH;
  localparam int CLR_W     = $clog2(MAX_DEPTH);
  localparam logic [15:0] RAM_MASK  = 16'(RAM_DEPTH - 1);
  localparam logic [15:0] SRAM_MASK = 16'(SRAM_DEPTH - 1);

  logic in_accept;

  bcmm_pkg::route_t   route;
  bcmm_pkg::mem_req_t mem_req;
  logic [1:0]         field_nxt;
  logic               dirty_nxt;

  // Clearing pass state
  logic             clearing_r, clearing_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Memory stage
  logic             p1_valid_r, p1_valid_nxt;
  bcmm_pkg::route_t p1_route_r;
  logic [1:0]       p1_field_r;
  logic             p1_dirty_r;
  logic             p1_move;

  // Output stage
  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_target_r;
  logic [bcmm_pkg::ROM_AW-1:0] out_rom_address_r;
  logic [7:0]                  out_read_data_r, out_read_data_nxt;
  logic [1:0]                  out_field_r;
  logic                        out_dirty_r;

  // Memory ports
  logic              ram_en, ram_we, sram_en, sram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [SRAM_AW-1:0] sram_addr;
  logic [7:0]        ram_wdata, sram_wdata, ram_rdata, sram_rdata;
  logic              ram_clr, sram_clr;

  // Advance the memory stage when the output register is free or drains
  assign p1_move   = ~out_valid_r | ~out_stall;
  assign in_stall  = clearing_r | (p1_valid_r & ~p1_move);
  assign in_accept = in_valid & ~in_stall;

  bcmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (in_accept),
    .operation  (in_operation),
    .address    (in_address),
    .write_data (in_write_data),
    .route      (route),
    .mem_req    (mem_req),
    .field_nxt  (field_nxt),
    .dirty_nxt  (dirty_nxt)
  );

  // Sweep both memories after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      if (clr_cnt_r == CLR_W'(MAX_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  assign ram_clr  = clearing_r & (32'(clr_cnt_r) < 32'(RAM_DEPTH));
  assign sram_clr = clearing_r & (32'(clr_cnt_r) < 32'(SRAM_DEPTH));

  // Select between the clearing sweep and item accesses
  always_comb begin
    if (clearing_r) begin
      ram_en     = ram_clr;
      ram_we     = 1'b1;
      ram_addr   = clr_cnt_r[RAM_AW-1:0];
      ram_wdata  = '0;
      sram_en    = sram_clr;
      sram_we    = 1'b1;
      sram_addr  = clr_cnt_r[SRAM_AW-1:0];
      sram_wdata = '0;
    end else begin
      ram_en     = mem_req.ram_en;
      ram_we     = mem_req.ram_we;
      ram_addr   = RAM_AW'(in_address & RAM_MASK);
      ram_wdata  = in_write_data;
      sram_en    = mem_req.sram_en;
      sram_we    = mem_req.sram_we;
      sram_addr  = SRAM_AW'(in_address & SRAM_MASK);
      sram_wdata = in_write_data;
    end
  end

  bcmm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_work_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bcmm_ram #(
    .WIDTH (8),
    .DEPTH (SRAM_DEPTH)
  ) u_cart_sram (
    .clk   (clk),
    .en    (sram_en),
    .we    (sram_we),
    .addr  (sram_addr),
    .wdata (sram_wdata),
    .rdata (sram_rdata)
  );

  // Memory stage control
  always_comb begin
    p1_valid_nxt = p1_valid_r;
    if (in_accept) begin
      p1_valid_nxt = 1'b1;
    end else if (p1_move) begin
      p1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p1_route_r <= route;
      p1_field_r <= field_nxt;
      p1_dirty_r <= dirty_nxt;
    end
  end

  // Pick the result byte from memory read data, open bus or zero
  always_comb begin
    case (p1_route_r.src)
      bcmm_pkg::SRC_RAM:  out_read_data_nxt = ram_rdata;
      bcmm_pkg::SRC_SRAM: out_read_data_nxt = sram_rdata;
      bcmm_pkg::SRC_OPEN: out_read_data_nxt = bcmm_pkg::OPEN_BUS;
      default:            out_read_data_nxt = 8'd0;
    endcase
  end

  // Output register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p1_move) begin
      out_valid_nxt = p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move && p1_valid_r) begin
      out_target_r      <= p1_route_r.target;
      out_rom_address_r <= p1_route_r.rom_address;
      out_read_data_r   <= out_read_data_nxt;
      out_field_r       <= p1_field_r;
      out_dirty_r       <= p1_dirty_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target        = out_target_r;
  assign out_rom_address   = out_rom_address_r;
  assign out_read_data     = out_read_data_r;
  assign out_glasses_field = out_field_r;
  assign out_sram_dirty    = out_dirty_r;

endmodule

@@ rtl/bcmm_ram.sv @@
module bcmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry; read data holds between reads
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/bcmm_ctrl.sv @@
module bcmm_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bcmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcmm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             accept,
  input  logic                             operation,
  input  logic [15:0]                      address,
  input  logic [7:0]                       write_data,
  output bcmm_pkg::route_t                 route,
  output bcmm_pkg::mem_req_t               mem_req,
  output logic [1:0]                       field_nxt,
  output logic                             dirty_nxt
);

  // Configuration registers
  logic                          bios_present_r;
  logic [bcmm_pkg::ROM_AW-1:0]   bios_mask_r;
  logic                          cart_present_r;
  logic [bcmm_pkg::ROM_AW-1:0]   rom_mask_r;
  logic [7:0]                    memory_control_r;

  // Mapper state
  logic [1:0] kind_r, kind_nxt;
  logic [5:0] bank_r [3];
  logic [5:0] bank_nxt [3];
  logic       sram_on_r, sram_on_nxt;
  logic       dirty_r;
  logic [1:0] field_r;

  logic       is_write;
  logic       in_sram_range;
  logic       in_ram_range;
  logic [1:0] kind_eff;
  logic [5:0] bank_sel;
  logic [13:0] offset;
  logic [bcmm_pkg::ROM_AW-1:0] base;
  logic [bcmm_pkg::ROM_AW-1:0] ext_addr;
  logic       bios_on;
  logic       cart_on;

  assign is_write      = accept & operation;
  assign in_sram_range = (address >= bcmm_pkg::ADDR_SRAM_LO) &&
                         (address <= bcmm_pkg::ADDR_SRAM_HI);
  assign in_ram_range  = (address >= bcmm_pkg::ADDR_RAM_LO);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bios_present_r   <= 1'b0;
      bios_mask_r      <= 20'd8191;
      cart_present_r   <= 1'b0;
      rom_mask_r       <= 20'hfffff;
      memory_control_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcmm_pkg::CFG_BIOS_PRESENT:   bios_present_r   <= cfg_wdata[0];
        bcmm_pkg::CFG_BIOS_MASK:      bios_mask_r      <= cfg_wdata;
        bcmm_pkg::CFG_CART_PRESENT:   cart_present_r   <= cfg_wdata[0];
        bcmm_pkg::CFG_ROM_MASK:       rom_mask_r       <= cfg_wdata;
        bcmm_pkg::CFG_MEMORY_CONTROL: memory_control_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Latch the mapper kind on the first register write
  always_comb begin
    kind_eff = kind_r;
    if (kind_r == bcmm_pkg::KIND_UNKNOWN) begin
      if (address >= bcmm_pkg::ADDR_CTRL) begin
        kind_eff = bcmm_pkg::KIND_HIGH;
      end else if (address == bcmm_pkg::ADDR_BANK1_LO ||
                   address == bcmm_pkg::ADDR_BANK2_LO) begin
        kind_eff = bcmm_pkg::KIND_SLOTREG;
      end else if (address == bcmm_pkg::ADDR_BANK2_A) begin
        kind_eff = bcmm_pkg::KIND_A000;
      end
    end
  end

  // Decode register writes of the latched kind
  always_comb begin
    kind_nxt    = kind_r;
    bank_nxt    = bank_r;
    sram_on_nxt = sram_on_r;
    field_nxt   = field_r;
    dirty_nxt   = dirty_r;
    if (is_write) begin
      kind_nxt = kind_eff;
      if (address >= bcmm_pkg::ADDR_FIELD_LO && address <= bcmm_pkg::ADDR_FIELD_HI) begin
        field_nxt = write_data[0] ? bcmm_pkg::FIELD_LEFT : bcmm_pkg::FIELD_RIGHT;
      end
      case (kind_eff)
        bcmm_pkg::KIND_HIGH: begin
          if (address == bcmm_pkg::ADDR_CTRL) begin
            sram_on_nxt = write_data[bcmm_pkg::CTRL_SRAM_BIT];
          end else if (address == bcmm_pkg::ADDR_BANK0_HI) begin
            bank_nxt[0] = write_data[5:0];
          end else if (address == bcmm_pkg::ADDR_BANK1_HI) begin
            bank_nxt[1] = write_data[5:0];
          end else if (address == bcmm_pkg::ADDR_BANK2_HI) begin
            bank_nxt[2] = write_data[5:0];
          end
        end
        bcmm_pkg::KIND_SLOTREG: begin
          if (address == bcmm_pkg::ADDR_BANK0_LO) begin
            bank_nxt[0] = write_data[5:0];
          end else if (address == bcmm_pkg::ADDR_BANK1_LO) begin
            bank_nxt[1] = write_data[5:0];
          end else if (address == bcmm_pkg::ADDR_BANK2_LO) begin
            bank_nxt[2] = write_data[5:0];
          end
        end
        bcmm_pkg::KIND_A000: begin
          if (address == bcmm_pkg::ADDR_BANK2_A) begin
            bank_nxt[2] = write_data[5:0];
          end
        end
        default: ;
      endcase
      // The control register lies outside the SRAM window, so the old enable decides
      if (sram_on_r && in_sram_range) begin
        dirty_nxt = 1'b1;
      end
    end
  end

  // Hold mapper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= bcmm_pkg::KIND_UNKNOWN;
      bank_r[0] <= 6'd0;
      bank_r[1] <= 6'd1;
      bank_r[2] <= 6'd2;
      sram_on_r <= 1'b0;
      dirty_r   <= 1'b0;
      field_r   <= bcmm_pkg::FIELD_NONE;
    end else begin
      kind_r    <= kind_nxt;
      bank_r    <= bank_nxt;
      sram_on_r <= sram_on_nxt;
      dirty_r   <= dirty_nxt;
      field_r   <= field_nxt;
    end
  end

  // Form the external ROM address of a slot read
  always_comb begin
    case (address[15:14])
      2'd0:    bank_sel = bank_r[0];
      2'd1:    bank_sel = bank_r[1];
      default: bank_sel = bank_r[2];
    endcase
  end

  assign offset = address[13:0];
  assign base   = (address[15:14] == 2'd0 && offset[13:10] == 4'd0) ?
                  '0 : {bank_sel, 14'd0};
  assign ext_addr = base + {6'd0, offset};
  assign bios_on  = bios_present_r & ~memory_control_r[bcmm_pkg::MC_BIOS_OFF_BIT];
  assign cart_on  = cart_present_r & ~memory_control_r[bcmm_pkg::MC_CART_OFF_BIT];

  // Route the item
  always_comb begin
    route.target      = bcmm_pkg::TGT_NONE;
    route.rom_address = '0;
    route.src         = bcmm_pkg::SRC_OPEN;
    if (operation) begin
      route.src = bcmm_pkg::SRC_ZERO;
    end else if (in_ram_range) begin
      route.target = bcmm_pkg::TGT_RAM;
      route.src    = bcmm_pkg::SRC_RAM;
    end else if (bios_on) begin
      route.target      = bcmm_pkg::TGT_BIOS;
      route.rom_address = ext_addr & bios_mask_r;
      route.src         = bcmm_pkg::SRC_ZERO;
    end else if (sram_on_r && address[15:14] == 2'd2) begin
      route.target = bcmm_pkg::TGT_SRAM;
      route.src    = bcmm_pkg::SRC_SRAM;
    end else if (cart_on) begin
      route.target      = bcmm_pkg::TGT_CART;
      route.rom_address = ext_addr & rom_mask_r;
      route.src         = bcmm_pkg::SRC_ZERO;
    end
  end

  // Request memory accesses
  assign mem_req.ram_en  = accept & in_ram_range;
  assign mem_req.ram_we  = operation;
  assign mem_req.sram_en = accept & (operation ? (sram_on_r & in_sram_range) :
                                     (route.src == bcmm_pkg::SRC_SRAM));
  assign mem_req.sram_we = operation;

endmodule
